>>> sv/bpa_pkg.sv
// Shared types and codes for the buddy page allocator.
`default_nettype none
package bpa_pkg;

  localparam int ORD_W = 4;
  localparam int PAGE_FIELD_W = 10;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_ORDER = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DOUBLE_FREE = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  // per-page head record
  typedef struct packed {
    logic             used;
    logic             valid;
    logic [ORD_W-1:0] order;
  } info_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SEARCH,
    S_FRD,
    S_FCHK,
    S_FLOOP,
    S_FBUD,
    S_MHIGH,
    S_MLOW,
    S_RMRD,
    S_RMUPD,
    S_SPLIT,
    S_APP1,
    S_APP2,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> sv/buddy_page_allocator_top.sv
// Buddy page allocator: sequencer, free-list registers and page memories.
//
// Usage: one request beat on the s_ group, one response beat on the m_ group.
// s_tuser carries the command (0 allocate, 1 free); s_tdata carries the
// wanted order and the page to free. m_tdata returns status and the head
// page of an allocated block.
// After reset the block runs a clearing pass over every page that loads
// the page memories with every top-order block free, chained ascending;
// s_tready stays low for that pass.
// One request is handled at a time by a small sequencer that walks the
// orders, one memory access per step on the three page memories.
// An allocate searches upward through the orders and then splits level by
// level; a free merges level by level until the buddy check stops the merge;
// a bad order or an out-of-range page goes straight to the response.
// s_tready rises in the same cycle that the response appears on m_tvalid.
// The response waits in an output register; the block takes the next
// request while it waits, and holds a new result until the receiver has
// taken the old one.
`default_nettype none
module buddy_page_allocator_top
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 1024,
  parameter int MAX_ORDER = 9
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [3:0] req_order, [13:4] free_page, [15:14] zero
  input  wire logic [15:0] s_tdata,
  // [0] command
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] status, [11:2] alloc_page, [15:12] zero
  output logic      [15:0] m_tdata
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int WA = (PW > MAX_ORDER + 1) ? PW : MAX_ORDER + 1;
  localparam int WW = ((WA > PAGE_FIELD_W) ? WA : PAGE_FIELD_W) + 2;
  localparam int NORD = MAX_ORDER + 1;
  localparam int OIW = $clog2(NORD);
  localparam int TOPN = NUM_PAGES >> MAX_ORDER;
  localparam int LASTH = (TOPN > 0) ? (TOPN - 1) * (1 << MAX_ORDER) : 0;
  localparam logic [WW-1:0] TOP_W = WW'(1) << MAX_ORDER;
  localparam logic [WW-1:0] NUM_W = WW'(NUM_PAGES);
  localparam logic [ORD_W-1:0] MAX_O = ORD_W'(MAX_ORDER);

  state_t state, state_next;

  logic [PW-1:0] icnt;
  logic [PW-1:0] blk, tgt;
  logic [ORD_W-1:0] ord, want;
  logic cmd;
  logic [STAT_W-1:0] stat;
  logic [PAGE_FIELD_W-1:0] res;
  logic [PW-1:0] lfirst [NORD];
  logic [PW-1:0] llast [NORD];
  logic [NORD-1:0] lne;

  // memory ports
  logic info_we, next_we, prev_we;
  logic [PW-1:0] info_wa, next_wa, prev_wa, raddr;
  info_t info_wd, info_rd;
  logic [PW-1:0] next_wd, prev_wd, next_rd, prev_rd;
  logic [$bits(info_t)-1:0] info_rd_raw;

  bpa_ram #(.DEPTH(NUM_PAGES), .AW(PW), .DW($bits(info_t))) u_info (
    .clk(clk), .we(info_we), .waddr(info_wa), .wdata(info_wd),
    .raddr(raddr), .rdata(info_rd_raw)
  );
  bpa_ram #(.DEPTH(NUM_PAGES), .AW(PW), .DW(PW)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(raddr), .rdata(next_rd)
  );
  bpa_ram #(.DEPTH(NUM_PAGES), .AW(PW), .DW(PW)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(raddr), .rdata(prev_rd)
  );

  assign info_rd = info_t'(info_rd_raw);

  // shared address arithmetic
  logic [OIW-1:0] oi;
  logic [WW-1:0] blk_w, icnt_w, bud_w, half_w, page_w;
  logic [ORD_W-1:0] ord_dn;
  logic [PW-1:0] low, high;
  logic is_first, is_last, out_free, s_fire;

  assign oi = ord[OIW-1:0];
  assign blk_w = WW'(blk);
  assign icnt_w = WW'(icnt);
  assign page_w = WW'(s_tdata[13:4]);
  assign bud_w = blk_w ^ (WW'(1) << ord);
  assign ord_dn = ord - ORD_W'(1);
  assign half_w = blk_w ^ (WW'(1) << ord_dn);
  assign low = (tgt < blk) ? tgt : blk;
  assign high = (tgt < blk) ? blk : tgt;
  assign is_first = lfirst[oi] == tgt;
  assign is_last = llast[oi] == tgt;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;
  assign s_fire = s_tvalid && s_tready;
  assign raddr = (state == S_FLOOP) ? bud_w[PW-1:0] : tgt;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory write ports
  always_comb begin
    state_next = state;
    info_we = 1'b0;
    next_we = 1'b0;
    prev_we = 1'b0;
    info_wa = tgt;
    next_wa = tgt;
    prev_wa = tgt;
    info_wd = '0;
    next_wd = tgt;
    prev_wd = tgt;
    case (state)
      S_INIT: begin
        info_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        info_wa = icnt;
        next_wa = icnt;
        prev_wa = icnt;
        info_wd.used = 1'b0;
        info_wd.valid = ((icnt_w & (TOP_W - WW'(1))) == '0) && (icnt_w + TOP_W <= NUM_W);
        info_wd.order = MAX_O;
        next_wd = (icnt_w + TOP_W + TOP_W <= NUM_W) ? PW'(icnt_w + TOP_W) : icnt;
        prev_wd = (icnt_w >= TOP_W) ? PW'(icnt_w - TOP_W) : icnt;
        if (icnt == PW'(NUM_PAGES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_fire) begin
          if (s_tuser == CMD_FREE) begin
            state_next = (page_w >= NUM_W) ? S_DONE : S_FRD;
          end else begin
            state_next = (s_tdata[3:0] > MAX_O) ? S_DONE : S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (lne[oi]) state_next = S_RMRD;
        else if (ord == MAX_O) state_next = S_DONE;
      end
      S_FRD: state_next = S_FCHK;
      S_FCHK: begin
        if (!info_rd.used || !info_rd.valid) begin
          state_next = S_DONE;
        end else begin
          info_we = 1'b1;
          info_wa = blk;
          info_wd = '{used: 1'b0, valid: 1'b1, order: info_rd.order};
          state_next = S_FLOOP;
        end
      end
      S_FLOOP: begin
        if (ord >= MAX_O || bud_w >= NUM_W) state_next = S_APP1;
        else state_next = S_FBUD;
      end
      S_FBUD: begin
        if (!info_rd.valid || info_rd.order != ord || info_rd.used) state_next = S_APP1;
        else state_next = S_RMRD;
      end
      S_RMRD: state_next = S_RMUPD;
      S_RMUPD: begin
        // unlink tgt from its list
        if (is_first && !is_last) begin
          prev_we = 1'b1;
          prev_wa = next_rd;
          prev_wd = next_rd;
        end else if (is_last && !is_first) begin
          next_we = 1'b1;
          next_wa = prev_rd;
          next_wd = prev_rd;
        end else if (!is_first && !is_last) begin
          next_we = 1'b1;
          next_wa = prev_rd;
          next_wd = next_rd;
          prev_we = 1'b1;
          prev_wa = next_rd;
          prev_wd = prev_rd;
        end
        if (cmd == CMD_ALLOC) begin
          info_we = 1'b1;
          info_wa = blk;
          info_wd = '{used: 1'b1, valid: 1'b1, order: want};
          state_next = S_SPLIT;
        end else begin
          state_next = S_MHIGH;
        end
      end
      S_MHIGH: begin
        info_we = 1'b1;
        info_wa = high;
        info_wd = '0;
        state_next = S_MLOW;
      end
      S_MLOW: begin
        info_we = 1'b1;
        info_wa = low;
        info_wd = '{used: 1'b0, valid: 1'b1, order: ord + ORD_W'(1)};
        state_next = S_FLOOP;
      end
      S_SPLIT: begin
        if (ord > want) begin
          if (half_w < NUM_W) state_next = S_APP1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_APP1: begin
        // link tgt behind the current tail
        info_we = 1'b1;
        info_wa = tgt;
        info_wd = '{used: 1'b0, valid: 1'b1, order: ord};
        prev_we = 1'b1;
        prev_wa = tgt;
        if (lne[oi]) begin
          next_we = 1'b1;
          next_wa = llast[oi];
          next_wd = tgt;
          prev_wd = llast[oi];
        end else begin
          prev_wd = tgt;
        end
        state_next = S_APP2;
      end
      S_APP2: begin
        next_we = 1'b1;
        next_wa = tgt;
        next_wd = tgt;
        state_next = (cmd == CMD_FREE) ? S_DONE : S_SPLIT;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      icnt <= '0;
      m_tvalid <= 1'b0;
      lne <= (TOPN > 0) ? (NORD'(1) << MAX_ORDER) : '0;
      for (int i = 0; i < NORD; i++) begin
        lfirst[i] <= '0;
        llast[i] <= (i == MAX_ORDER) ? PW'(LASTH) : '0;
      end
    end else begin
      // load a new response or drop the taken one
      if (state == S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_INIT: icnt <= icnt + PW'(1);
        S_IDLE: begin
          if (s_fire) begin
            cmd <= s_tuser;
            want <= s_tdata[3:0];
            ord <= s_tdata[3:0];
            blk <= PW'(page_w);
            tgt <= PW'(page_w);
            res <= '0;
            if (s_tuser == CMD_FREE && page_w >= NUM_W) begin
              stat <= STAT_DOUBLE_FREE;
            end else if (s_tuser == CMD_ALLOC && s_tdata[3:0] > MAX_O) begin
              stat <= STAT_BAD_ORDER;
            end else begin
              stat <= STAT_OK;
            end
          end
        end
        S_SEARCH: begin
          if (lne[oi]) begin
            blk <= lfirst[oi];
            tgt <= lfirst[oi];
          end else if (ord == MAX_O) begin
            stat <= STAT_NO_SPACE;
          end else begin
            ord <= ord + ORD_W'(1);
          end
        end
        S_FCHK: begin
          if (!info_rd.used || !info_rd.valid) stat <= STAT_DOUBLE_FREE;
          else ord <= info_rd.order;
        end
        S_FLOOP: begin
          if (ord >= MAX_O || bud_w >= NUM_W) tgt <= blk;
          else tgt <= bud_w[PW-1:0];
        end
        S_FBUD: begin
          if (!info_rd.valid || info_rd.order != ord || info_rd.used) tgt <= blk;
        end
        S_RMUPD: begin
          if (is_first && is_last) begin
            lne[oi] <= 1'b0;
          end else if (is_first) begin
            lfirst[oi] <= next_rd;
          end else if (is_last) begin
            llast[oi] <= prev_rd;
          end
        end
        S_MLOW: begin
          blk <= low;
          ord <= ord + ORD_W'(1);
        end
        S_SPLIT: begin
          if (ord > want) begin
            ord <= ord_dn;
            tgt <= half_w[PW-1:0];
          end else begin
            res <= blk_w[PAGE_FIELD_W-1:0];
          end
        end
        S_APP1: begin
          if (!lne[oi]) begin
            lfirst[oi] <= tgt;
            lne[oi] <= 1'b1;
          end
        end
        S_APP2: llast[oi] <= tgt;
        S_DONE: begin
          if (out_free) begin
            m_tdata <= {4'd0, res, stat};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/bpa_ram.sv
// Single-write, single-read memory with registered read data.
`default_nettype none
module bpa_ram #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int DW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the buddy page allocator.
`timescale 1ns / 1ps
module tb_top;
  import bpa_pkg::*;

  localparam int NPAGES = 1024;
  localparam int TOP_ORD = 9;
  localparam int NORD = TOP_ORD + 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [PAGE_FIELD_W-1:0] page;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  buddy_page_allocator_top #(.NUM_PAGES(NPAGES), .MAX_ORDER(TOP_ORD)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // shadow allocator state
  logic [ORD_W-1:0] sh_order [NPAGES];
  logic             sh_valid [NPAGES];
  logic             sh_used  [NPAGES];
  int unsigned      sh_next  [NPAGES];
  int unsigned      sh_prev  [NPAGES];
  int unsigned      sh_first [NORD];
  int unsigned      sh_last  [NORD];
  logic             sh_ne    [NORD];

  resp_t       pending_resp[$];
  int unsigned held_pages[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  initial forever #6 clk = ~clk;

  // generous watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void list_push(int unsigned p, int unsigned o);
    if (sh_ne[o]) begin
      sh_next[sh_last[o]] = p;
      sh_prev[p] = sh_last[o];
    end else begin
      sh_first[o] = p;
      sh_prev[p] = p;
      sh_ne[o] = 1'b1;
    end
    sh_next[p] = p;
    sh_last[o] = p;
  endfunction

  function automatic void list_unlink(int unsigned p, int unsigned o);
    bit is_f;
    bit is_l;
    is_f = sh_first[o] == p;
    is_l = sh_last[o] == p;
    if (is_f && is_l) begin
      sh_ne[o] = 1'b0;
    end else if (is_f) begin
      sh_first[o] = sh_next[p];
      sh_prev[sh_next[p]] = sh_next[p];
    end else if (is_l) begin
      sh_last[o] = sh_prev[p];
      sh_next[sh_prev[p]] = sh_prev[p];
    end else begin
      sh_next[sh_prev[p]] = sh_next[p];
      sh_prev[sh_next[p]] = sh_prev[p];
    end
    sh_next[p] = p;
    sh_prev[p] = p;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NPAGES; i++) begin
      sh_order[i] = '0;
      sh_valid[i] = 1'b0;
      sh_used[i] = 1'b0;
      sh_next[i] = 0;
      sh_prev[i] = 0;
    end
    for (int o = 0; o < NORD; o++) begin
      sh_first[o] = 0;
      sh_last[o] = 0;
      sh_ne[o] = 1'b0;
    end
    for (int i = 0; i + (1 << TOP_ORD) <= NPAGES; i += (1 << TOP_ORD)) begin
      sh_order[i] = ORD_W'(TOP_ORD);
      sh_valid[i] = 1'b1;
      list_push(i, TOP_ORD);
    end
  endfunction

  // work out the response of one request and update the shadow state
  function automatic resp_t predict_request(logic cmd, int unsigned want, int unsigned pg);
    resp_t r;
    int unsigned o;
    int unsigned blk;
    int unsigned bud;
    int unsigned lo;
    int unsigned hi;
    r.status = STAT_OK;
    r.page = '0;
    if (cmd == CMD_ALLOC) begin
      if (want > TOP_ORD) begin
        r.status = STAT_BAD_ORDER;
      end else begin
        o = want;
        while (o <= TOP_ORD && !sh_ne[o]) o++;
        if (o > TOP_ORD) begin
          r.status = STAT_NO_SPACE;
        end else begin
          blk = sh_first[o];
          list_unlink(blk, o);
          sh_used[blk] = 1'b1;
          sh_order[blk] = ORD_W'(want);
          sh_valid[blk] = 1'b1;
          while (o > want) begin
            o--;
            hi = blk ^ (1 << o);
            if (hi < NPAGES) begin
              sh_order[hi] = ORD_W'(o);
              sh_valid[hi] = 1'b1;
              list_push(hi, o);
            end
          end
          r.page = PAGE_FIELD_W'(blk);
        end
      end
    end else begin
      if (pg >= NPAGES || !sh_used[pg] || !sh_valid[pg]) begin
        r.status = STAT_DOUBLE_FREE;
      end else begin
        blk = pg;
        o = sh_order[pg];
        sh_used[blk] = 1'b0;
        while (o < TOP_ORD) begin
          bud = blk ^ (1 << o);
          if (bud >= NPAGES || !sh_valid[bud] || sh_order[bud] != o || sh_used[bud]) break;
          list_unlink(bud, o);
          lo = bud < blk ? bud : blk;
          hi = bud < blk ? blk : bud;
          sh_valid[hi] = 1'b0;
          sh_order[hi] = '0;
          o++;
          sh_order[lo] = ORD_W'(o);
          sh_valid[lo] = 1'b1;
          blk = lo;
        end
        list_push(blk, o);
      end
    end
    return r;
  endfunction

  // send one request beat, predicting at acceptance
  task automatic send_request(logic cmd, logic [3:0] want, logic [9:0] pg);
    resp_t r;
    // hold valid across back-to-back beats; drop it only while idle
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, pg, want};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_request(cmd, 32'(want), 32'(pg));
    pending_resp.push_back(r);
    if (cmd == CMD_ALLOC && r.status == STAT_OK) held_pages.push_back(r.page);
    n_sent++;
  endtask

  // receiver: random stall, compare each response beat
  always @(posedge clk) begin
    resp_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_resp.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = pending_resp.pop_front();
        if (m_tdata[1:0] !== exp_r.status || m_tdata[11:2] !== exp_r.page ||
            m_tdata[15:12] !== 4'd0) begin
          $display("%0t: expected status %0d page %0d, actual status %0d page %0d",
                   $time, exp_r.status, exp_r.page, m_tdata[1:0], m_tdata[11:2]);
          errors++;
        end
        n_checked++;
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic free_random_held();
    int k;
    int unsigned p;
    k = $urandom_range(held_pages.size() - 1);
    p = held_pages[k];
    held_pages.delete(k);
    send_request(CMD_FREE, 4'($urandom), 10'(p));
  endtask

  task automatic test_directed();
    send_request(CMD_ALLOC, 4'd0, 10'd0);
    send_request(CMD_ALLOC, 4'd9, 10'h3ff);
    send_request(CMD_ALLOC, 4'd10, 10'd0);
    send_request(CMD_ALLOC, 4'd15, 10'h3ff);
    send_request(CMD_ALLOC, 4'd9, 10'd0);
    send_request(CMD_ALLOC, 4'd1, 10'd0);
    // free head page, interior pages, a good free, then a double free
    send_request(CMD_FREE, 4'd0, 10'd1);
    send_request(CMD_FREE, 4'd0, 10'd700);
    send_request(CMD_FREE, 4'd0, 10'h3ff);
    send_request(CMD_FREE, 4'd15, 10'd0);
    send_request(CMD_FREE, 4'd0, 10'd0);
    // run out of order-8 blocks, then free everything back
    for (int i = 0; i < 6; i++) send_request(CMD_ALLOC, 4'd8, 10'd0);
    while (held_pages.size() > 0) free_random_held();
  endtask

  task automatic test_random(int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        send_request(CMD_ALLOC,
                     4'($urandom_range(0, 4) + ($urandom_range(9) == 0 ? 5 : 0)),
                     10'($urandom));
      end else if (roll < 85 && held_pages.size() > 0) begin
        free_random_held();
      end else if (roll < 92) begin
        send_request(CMD_ALLOC, 4'($urandom), 10'($urandom));
      end else begin
        send_request(CMD_FREE, 4'($urandom), 10'($urandom));
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_resp.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    shadow_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    drain();
    test_random(110);
    send_idle = 65;
    test_random(110);
    send_idle = 0;
    recv_stall = 65;
    test_random(110);
    send_idle = 33;
    recv_stall = 33;
    test_random(110);
    drain();
    $display("Sent %0d requests, checked %0d responses, across four idle/stall phases",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/buddy_page_allocator_top.sv
test/tb_top.sv
